// File: rtl/qrs_pkg.sv
package qrs_pkg;

   // Number of cells in the square-root row and in the divider row.
   localparam int SQRT_STEPS = 17;
   localparam int DIV_STEPS  = 17;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NEG   = 2'd1,
      ST_AZERO = 2'd2
   } status_type;

   // Per-item context that rides along with the datapath.
   typedef struct packed {
      status_type         status;
      logic signed [33:0] disc;
      logic signed [15:0] coef_a;
      logic signed [15:0] coef_b;
   } ctx_type;

   // Bit-by-bit square root state: remaining radicand and partial root.
   typedef struct packed {
      logic [33:0] rem;
      logic [33:0] res;
   } sqrt_type;

   // One restoring-division lane: partial remainder, dividend/quotient shift
   // register and the sign to apply to the quotient at the end.
   typedef struct packed {
      logic [16:0] rem;
      logic [16:0] quo;
      logic        neg;
   } div_lane_type;

   typedef struct packed {
      div_lane_type plus;
      div_lane_type minus;
      logic [16:0]  divisor;
      ctx_type      ctx;
   } div_type;

   typedef struct packed {
      status_type         status;
      logic signed [33:0] disc;
      logic signed [16:0] root_plus;
      logic signed [16:0] root_minus;
   } res_type;

endpackage

// File: rtl/qrs_sqrt_cell.sv
module qrs_sqrt_cell
   import qrs_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_vld,
   input  ctx_type  in_ctx,
   input  sqrt_type in_sq,
   output logic     out_vld_ff,
   output ctx_type  out_ctx_ff,
   output sqrt_type out_sq_ff
);

   // Each cell resolves one root bit, from weight 2^16 down; its trial term starts at 2^32.
   localparam int          BIT_POS = 32 - 2 * STEP;
   localparam logic [33:0] BIT_VAL = 34'(1) << BIT_POS;

   logic [33:0] trial;
   sqrt_type    sq_in;

   always_comb begin
      trial = in_sq.res + BIT_VAL;
      if (in_sq.rem >= trial) begin
         sq_in.rem = in_sq.rem - trial;
         sq_in.res = (in_sq.res >> 1) + BIT_VAL;
      end else begin
         sq_in.rem = in_sq.rem;
         sq_in.res = in_sq.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ctx_ff <= in_ctx;
         out_sq_ff  <= sq_in;
      end
   end

endmodule

// File: rtl/qrs_div_cell.sv
module qrs_div_cell
   import qrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    in_vld,
   input  div_type in_dv,
   output logic    out_vld_ff,
   output div_type out_dv_ff
);

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   function automatic div_lane_type div_step(div_lane_type ln, logic [16:0] dvsr);
      logic [17:0]  sh;
      logic         ge;
      logic [17:0]  diff;
      div_lane_type nx;
      sh   = {ln.rem, ln.quo[16]};
      ge   = (sh >= {1'b0, dvsr});
      diff = sh - {1'b0, dvsr};
      nx.rem = ge ? diff[16:0] : sh[16:0];
      nx.quo = {ln.quo[15:0], ge};
      nx.neg = ln.neg;
      return nx;
   endfunction

   div_type dv_in;

   always_comb begin
      dv_in         = in_dv;
      dv_in.plus    = div_step(in_dv.plus, in_dv.divisor);
      dv_in.minus   = div_step(in_dv.minus, in_dv.divisor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_dv_ff <= dv_in;
      end
   end

endmodule

// File: rtl/quadratic_root_solver_top.sv
// Real roots of a*x^2 + b*x + c from three signed 16-bit coefficients.
// One item on the req_ channel carries a, b and c; exactly one item comes
// back on the rsp_ channel with a status in rsp_tuser and the discriminant
// and both roots in rsp_tdata. Roots are the exact quotients truncated
// toward zero; they read zero when the status is not "roots valid".
// The datapath is a pipeline: a multiply stage, a discriminant stage, a row
// of 17 square-root cells (one root bit each), a numerator stage, a row of
// 17 divider cells (one quotient bit each for both roots) and a sign stage.
// Items flow through these stages into the output register, and a new item
// can be accepted every cycle while req_tready is high (one item per cycle).
// A two-entry output (output register plus skid register) lets the pipeline
// keep moving while a result waits; when the receiver stalls long enough for
// the skid register to fill, req_tready drops and the whole row holds.
// req_tready depends only on registers and reset and never on rsp_tready in
// the same cycle. Reset clears all valid bits and holds req_tready low; items
// in flight are dropped and an item can be accepted at the first clock edge
// after reset goes low.
module quadratic_root_solver_top
   import qrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // coef_a [15:0], coef_b [31:16], coef_c [47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // discriminant [33:0], root_plus [50:34],
                                    // root_minus [67:51], zero fill [71:68]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   // The whole pipeline advances whenever the skid register is empty.
   logic en;
   logic skid_vld_ff;
   assign en         = !skid_vld_ff;
   assign req_tready = en && !reset;

   // Multiply stage: b*b and a*c.
   logic signed [15:0] in_a, in_b, in_c;
   assign in_a = req_tdata[15:0];
   assign in_b = req_tdata[31:16];
   assign in_c = req_tdata[47:32];

   logic               m_vld_ff;
   logic signed [31:0] m_bb_ff, m_ac_ff;
   logic signed [15:0] m_a_ff, m_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (en) begin
         m_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_bb_ff <= 32'(in_b) * 32'(in_b);
         m_ac_ff <= 32'(in_a) * 32'(in_c);
         m_a_ff  <= in_a;
         m_b_ff  <= in_b;
      end
   end

   // Discriminant stage, feeding the first square-root cell.
   logic               sq_vld [0:SQRT_STEPS];
   ctx_type            sq_ctx [0:SQRT_STEPS];
   sqrt_type           sq_dat [0:SQRT_STEPS];
   logic               d_vld_ff;
   ctx_type            d_ctx_ff, d_ctx_in;
   sqrt_type           d_sq_ff, d_sq_in;
   logic signed [33:0] disc_w;

   always_comb begin
      disc_w          = 34'(m_bb_ff) - (34'(m_ac_ff) <<< 2);
      d_ctx_in.disc   = disc_w;
      d_ctx_in.coef_a = m_a_ff;
      d_ctx_in.coef_b = m_b_ff;
      if (m_a_ff == 16'sd0) begin
         d_ctx_in.status = ST_AZERO;
      end else if (disc_w[33]) begin
         d_ctx_in.status = ST_NEG;
      end else begin
         d_ctx_in.status = ST_OK;
      end
      // Only a valid case goes through the root; others run on zero.
      d_sq_in.rem = (d_ctx_in.status == ST_OK) ? disc_w : 34'd0;
      d_sq_in.res = 34'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ctx_ff <= d_ctx_in;
         d_sq_ff  <= d_sq_in;
      end
   end

   assign sq_vld[0] = d_vld_ff;
   assign sq_ctx[0] = d_ctx_ff;
   assign sq_dat[0] = d_sq_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      qrs_sqrt_cell #(.STEP(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .in_vld     (sq_vld[i]),
         .in_ctx     (sq_ctx[i]),
         .in_sq      (sq_dat[i]),
         .out_vld_ff (sq_vld[i+1]),
         .out_ctx_ff (sq_ctx[i+1]),
         .out_sq_ff  (sq_dat[i+1])
      );
   end

   // Numerator stage. With a negative denominator the numerator and the
   // sign of the root term are flipped so that the divisor is positive.
   // Each root then becomes a magnitude to divide and a sign to apply,
   // where a negative irrational numerator rounds its magnitude down.
   function automatic div_lane_type root_num(logic signed [17:0] m, logic [16:0] s,
                                             logic exact, logic up);
      logic signed [17:0] fl;
      div_lane_type       ln;
      fl = up ? (m + 18'(s)) : (m - 18'(s) - (exact ? 18'sd0 : 18'sd1));
      ln.neg = fl[17];
      ln.rem = 17'd0;
      if (!fl[17]) begin
         ln.quo = fl[16:0];
      end else if (exact) begin
         ln.quo = 17'(-fl);
      end else begin
         ln.quo = 17'(~fl);
      end
      return ln;
   endfunction

   logic               dv_vld [0:DIV_STEPS];
   div_type            dv_dat [0:DIV_STEPS];
   logic               p_vld_ff;
   div_type            p_dv_ff, p_dv_in;
   ctx_type            s_ctx;
   sqrt_type           s_sq;
   logic               neg_a, exact;
   logic signed [17:0] m_num;
   logic signed [16:0] den2;

   always_comb begin
      s_ctx   = sq_ctx[SQRT_STEPS];
      s_sq    = sq_dat[SQRT_STEPS];
      neg_a   = s_ctx.coef_a[15];
      exact   = (s_sq.rem == 34'd0);
      m_num   = neg_a ? 18'(s_ctx.coef_b) : -18'(s_ctx.coef_b);
      den2    = {s_ctx.coef_a, 1'b0};
      p_dv_in.ctx     = s_ctx;
      p_dv_in.divisor = neg_a ? 17'(-den2) : 17'(den2);
      p_dv_in.plus    = root_num(m_num, s_sq.res[16:0], exact, !neg_a);
      p_dv_in.minus   = root_num(m_num, s_sq.res[16:0], exact, neg_a);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff <= sq_vld[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_dv_ff <= p_dv_in;
      end
   end

   assign dv_vld[0] = p_vld_ff;
   assign dv_dat[0] = p_dv_ff;

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      qrs_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .in_vld     (dv_vld[j]),
         .in_dv      (dv_dat[j]),
         .out_vld_ff (dv_vld[j+1]),
         .out_dv_ff  (dv_dat[j+1])
      );
   end

   // Sign stage: apply signs, force roots to zero on an error status.
   logic    f_vld_ff;
   res_type f_ff, f_in;
   div_type q_dv;

   always_comb begin
      q_dv          = dv_dat[DIV_STEPS];
      f_in.status   = q_dv.ctx.status;
      f_in.disc     = q_dv.ctx.disc;
      f_in.root_plus  = q_dv.plus.neg  ? -q_dv.plus.quo  : q_dv.plus.quo;
      f_in.root_minus = q_dv.minus.neg ? -q_dv.minus.quo : q_dv.minus.quo;
      if (q_dv.ctx.status != ST_OK) begin
         f_in.root_plus  = 17'sd0;
         f_in.root_minus = 17'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (en) begin
         f_vld_ff <= dv_vld[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff <= f_in;
      end
   end

   // Output register plus skid register.
   logic    out_vld_ff, out_vld_in, skid_vld_in, take;
   res_type out_ff, out_in, skid_ff, skid_in;

   assign take = out_vld_ff && rsp_tready;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (!out_vld_ff || take) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in  = f_vld_ff;
            out_in      = f_ff;
         end
      end else if (f_vld_ff && en) begin
         skid_vld_in = 1'b1;
         skid_in     = f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {4'd0, out_ff.root_minus, out_ff.root_plus, out_ff.disc};

   // A full skid register always sits behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid register full while output register empty");

   // Error statuses carry zero roots.
   a_err_zero_roots: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> (rsp_tdata[67:34] == 34'd0))
      else $error("nonzero roots on an error status");

   // Valid roots only come with a nonnegative discriminant.
   a_ok_disc_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_OK) |-> !rsp_tdata[33])
      else $error("roots reported for a negative discriminant");

   // The square-root row leaves a remainder no larger than twice the root.
   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      sq_vld[SQRT_STEPS] |-> (s_sq.rem <= (s_sq.res << 1)))
      else $error("square-root remainder out of range");

endmodule

// File: tb/root_checker.sv
`timescale 1ns / 100ps

module root_checker
   import qrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_roots,
   output int          root_count,
   output int          status_seen [3]
);

   res_type expected_roots [$];

   // Truncated quotient of (m + t*sqrt(D)) / den, built from floor sqrt s.
   function automatic longint trunc_quot(longint m, int t, longint s, bit exact,
                                        longint den);
      longint d;
      longint fl;
      if (den < 0) begin
         d = -den;
         m = -m;
         t = -t;
      end else begin
         d = den;
      end
      if (t > 0) fl = m + s;
      else fl = m - s - (exact ? 0 : 1);
      if (fl >= 0) return fl / d;
      // Numerator negative: truncation of the real value uses its ceiling.
      return -((exact ? -fl : -fl - 1) / d);
   endfunction

   function automatic res_type solve_roots(logic [47:0] coefs);
      longint a;
      longint b;
      longint c;
      longint disc;
      longint s;
      res_type r;
      a = longint'($signed(coefs[15:0]));
      b = longint'($signed(coefs[31:16]));
      c = longint'($signed(coefs[47:32]));
      disc = b * b - 4 * a * c;
      r.disc = disc[33:0];
      r.root_plus = '0;
      r.root_minus = '0;
      if (a == 0) begin
         r.status = ST_AZERO;
      end else if (disc < 0) begin
         r.status = ST_NEG;
      end else begin
         s = 0;
         for (int k = 16; k >= 0; k--)
            if ((s + (64'd1 << k)) * (s + (64'd1 << k)) <= disc) s += 64'd1 << k;
         r.status = ST_OK;
         r.root_plus = 17'(trunc_quot(-b, 1, s, s * s == disc, 2 * a));
         r.root_minus = 17'(trunc_quot(-b, -1, s, s * s == disc, 2 * a));
      end
      return r;
   endfunction

   assign pending_roots = expected_roots.size();

   always @(posedge clock) begin
      res_type want;
      res_type got;
      if (reset) begin
         fail_count <= 0;
         root_count <= 0;
         status_seen <= '{0, 0, 0};
         expected_roots.delete();
      end else begin
         if (req_tvalid && req_tready) expected_roots.push_back(solve_roots(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tuser);
            got.disc = rsp_tdata[33:0];
            got.root_plus = rsp_tdata[50:34];
            got.root_minus = rsp_tdata[67:51];
            root_count <= root_count + 1;
            if (expected_roots.size() == 0) begin
               $display("%0t: unexpected result, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_roots.pop_front();
               status_seen[want.status] <= status_seen[want.status] + 1;
               if (got.status != want.status || got.disc != want.disc ||
                   got.root_plus != want.root_plus || got.root_minus != want.root_minus ||
                   rsp_tdata[71:68] != 4'd0) begin
                  $display("%0t: mismatch, expected st=%0d d=%0d rp=%0d rm=%0d",
                           $time, want.status, want.disc, want.root_plus, want.root_minus);
                  $display("%0t:          actual   st=%0d d=%0d rp=%0d rm=%0d fill=%h",
                           $time, got.status, got.disc, got.root_plus, got.root_minus,
                           rsp_tdata[71:68]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import qrs_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int fail_count;
   int pending_roots;
   int root_count;
   int status_seen [3];
   int cycle_count = 0;

   // Pipeline depth of the block; this bounds the final drain.
   localparam int PIPE_CYCLES = 39;
   localparam int CYCLE_LIMIT = 200000;

   always #10 clock = ~clock;

   quadratic_root_solver_top dut (.*);

   root_checker checker_inst (.*);

   // Global watchdog. The slowest correct run, about 1125 items with their
   // gaps and stalls, stays well below this limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[quadratic_root_solver_top] ERROR");
         $finish;
      end
   end

   // The receiver stalls a random number of cycles before each item it takes.
   // At least one time in four it takes with no stall, so bursts of
   // back-to-back results are also exercised.
   initial begin : result_sink
      int wait_cycles;
      @(negedge reset);
      forever begin
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         repeat (wait_cycles) @(posedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         rsp_tready <= 1'b0;
      end
   end

   // Sends one coefficient set and holds it until the block takes it.
   // When no gap is wanted, the valid stays high across items.
   task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] c, bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {c, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Picks a coefficient: a small value, a full-range value or an edge.
   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2, 3: return 16'($signed($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
      logic signed [15:0] r1;
      logic signed [15:0] r2;
      bit burst;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a zero, negative discriminant, perfect squares, irrational
      // roots of both signs, and the extremes of every coefficient.
      send_coefs(16'sd0, 16'sd5, 16'sd3, 0);
      send_coefs(16'sd0, -16'sd32768, 16'sd0, 0);
      send_coefs(16'sd1, 16'sd0, 16'sd1, 0);
      send_coefs(16'sd1, -16'sd3, 16'sd2, 0);
      send_coefs(-16'sd1, 16'sd3, -16'sd2, 0);
      send_coefs(16'sd1, 16'sd0, -16'sd2, 0);
      send_coefs(-16'sd3, 16'sd1, 16'sd7, 0);
      send_coefs(16'sd2, 16'sd5, -16'sd1, 0);
      send_coefs(16'sd1, 16'sd2, 16'sd1, 0);
      send_coefs(16'sd1, 16'sd0, 16'sd0, 0);
      send_coefs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
      send_coefs(16'sh8000, 16'sh8000, 16'sh8000, 0);
      send_coefs(16'sh8000, 16'sh8000, 16'sh7FFF, 0);
      send_coefs(16'sh7FFF, 16'sh8000, 16'sh8000, 0);
      send_coefs(16'sd1, 16'sh8000, 16'sh8000, 0);
      send_coefs(-16'sd1, 16'sh8000, 16'sh7FFF, 0);
      send_coefs(16'sd1, 16'sh7FFF, 16'sh8000, 0);
      send_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      send_coefs(16'sh7FFF, 16'sd0, 16'sh8000, 0);

      // Hold off the sender until every outstanding result has come back.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_roots != 0) @(posedge clock);

      // Random part. Half the sets are built from chosen integer roots so the
      // valid-roots path gets plenty of exact and near-exact cases.
      for (int n = 0; n < 1100; n++) begin
         if (n % 100 == 0) burst = ($urandom_range(0, 2) == 0);
         if ($urandom_range(0, 1) == 0) begin
            r1 = 16'($signed($urandom_range(0, 200)) - 100);
            r2 = 16'($signed($urandom_range(0, 200)) - 100);
            a = 16'($signed($urandom_range(1, 3)));
            if ($urandom_range(0, 1)) a = -a;
            b = 16'(-a * (r1 + r2));
            c = 16'(a * r1 * r2 + $signed($urandom_range(0, 2)) - 1);
         end else begin
            a = pick_coef();
            b = pick_coef();
            c = pick_coef();
         end
         send_coefs(a, b, c, burst);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_roots != 0) @(posedge clock);
      repeat (PIPE_CYCLES + 10) @(posedge clock);

      $display("Checked %0d results: %0d with roots, %0d negative discriminant, %0d a zero.",
               root_count, status_seen[ST_OK], status_seen[ST_NEG], status_seen[ST_AZERO]);
      if (fail_count == 0 && pending_roots == 0)
         $display("[quadratic_root_solver_top] OK");
      else
         $display("[quadratic_root_solver_top] ERROR");
      $finish;
   end

endmodule
